@@ src/opnbit_pkg.sv @@
// Shared types, codes and helper functions of the sound-chip bus interface and timers.
package opnbit_pkg;

    localparam int REG_COUNT_DEF = 256;

    localparam logic [15:0] PORT_CMD = 16'hFD45;
    localparam logic [15:0] PORT_DAT = 16'hFD46;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_TIMER_A = 2'd2;
    localparam logic [1:0] OP_TIMER_B = 2'd3;

    localparam logic [3:0] CMD_INACTIVE = 4'd0;
    localparam logic [3:0] CMD_READ     = 4'd1;
    localparam logic [3:0] CMD_WRITE    = 4'd2;
    localparam logic [3:0] CMD_ADDRESS  = 4'd3;
    localparam logic [3:0] CMD_STATUS   = 4'd4;
    localparam logic [3:0] CMD_JOY      = 4'd9;

    localparam logic CFG_DEVICE_ENABLE = 1'b0;
    localparam logic CFG_NEW_MACHINE   = 1'b1;

    localparam logic [7:0] REG_JOY       = 8'h0E;
    localparam logic [7:0] REG_RB_LIMIT  = 8'h10;
    localparam logic [7:0] REG_TMA_HI    = 8'h24;
    localparam logic [7:0] REG_TMA_LO    = 8'h25;
    localparam logic [7:0] REG_TMB       = 8'h26;
    localparam logic [7:0] REG_TCTL      = 8'h27;
    localparam logic [7:0] REG_KEY       = 8'h28;
    localparam logic [7:0] REG_QUIET_LO  = 8'h29;
    localparam logic [7:0] REG_PSC6      = 8'h2D;
    localparam logic [7:0] REG_PSC3      = 8'h2E;
    localparam logic [7:0] REG_PSC2      = 8'h2F;
    localparam logic [7:0] REG_CSM       = 8'hFF;

    localparam logic [2:0] PSC_2 = 3'd2;
    localparam logic [2:0] PSC_3 = 3'd3;
    localparam logic [2:0] PSC_6 = 3'd6;

    // period = count * prescale * 625 / 64 (timer A) or / 4 (timer B)
    localparam int MUL_STEPS = 12;
    localparam int MCAND_W   = 11;
    localparam int ACC_W     = 22;
    localparam int CNT_W     = $clog2(MUL_STEPS + 1);
    localparam int A_SHIFT   = 6;
    localparam int B_SHIFT   = 2;
    localparam int PER_A_W   = 16;
    localparam int PER_B_W   = 18;

    typedef enum logic [2:0] {
        MODE_INACTIVE = 3'd0,
        MODE_READ     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_ADDRESS  = 3'd3,
        MODE_STATUS   = 3'd4,
        MODE_JOY      = 3'd5
    } t_port_mode;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_CALC_A = 4'b0100,
        S_CALC_B = 4'b1000
    } t_seq_state;

    function automatic logic [7:0] reg_default(input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        if (addr == 8'h07) begin
            v = 8'hFF;
        end else if (addr[1:0] != 2'b11) begin
            case (addr[7:4])
                4'h4:    v = 8'h7F;
                4'h5:    v = 8'h1F;
                4'h8:    v = 8'hFF;
                default: v = 8'h00;
            endcase
        end
        return v;
    endfunction

    function automatic logic [MUL_STEPS-1:0] prescale_mult(input logic [2:0] psc);
        logic [MUL_STEPS-1:0] k;
        case (psc)
            PSC_2:   k = MUL_STEPS'(1250);
            PSC_3:   k = MUL_STEPS'(1875);
            PSC_6:   k = MUL_STEPS'(3750);
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ src/opnbit_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module opnbit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/opn_bus_interface_timers.sv @@
// Top level: command/data port decoder, register file and timer period sequencer.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  request   | i_opcode, i_bus_address, i_write_data   | start high while busy low
//  result    | o_handled ... o_key_flags               | o_done, one-cycle strobe
//  config    | i_cfg_idx, i_cfg_data                   | i_cfg_we, written at once
//
//  busy is high while a request executes, and stays high while the request
//  recomputes timer periods on the shared shift-add multiplier (timer A first).
//  o_done pulses in the first cycle in which busy is low; the receiver cannot stall it.
//  Reset is synchronous; register file defaults come from per-entry valid bits,
//  so no clearing pass is needed.
module opn_bus_interface_timers #(
    parameter int REG_COUNT = opnbit_pkg::REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    output logic        o_done,
    output logic        o_handled,
    output logic [7:0]  o_read_data,
    output logic        o_irq_level,
    output logic        o_notify_valid,
    output logic [7:0]  o_notify_reg,
    output logic [7:0]  o_notify_data,
    output logic [15:0] o_timer_a_period,
    output logic [17:0] o_timer_b_period,
    output logic        o_timer_a_restart,
    output logic        o_timer_b_restart,
    output logic [3:0]  o_key_flags
);

    localparam int REG_AW = $clog2(REG_COUNT);

    opnbit_pkg::t_seq_state r_state, n_state;
    opnbit_pkg::t_port_mode r_mode, n_mode;

    logic        r_dev_en, r_new_mach;
    logic [1:0]  r_req_op;
    logic [15:0] r_req_addr;
    logic [7:0]  r_req_wd;

    logic [7:0]  r_sel, n_sel;
    logic [7:0]  r_latch, n_latch;
    logic        r_ovf_a, n_ovf_a, r_ovf_b, n_ovf_b;
    logic        r_run_a, n_run_a, r_run_b, n_run_b;
    logic        r_arm_a, n_arm_a, r_arm_b, n_arm_b;
    logic        r_irq, n_irq;
    logic [2:0]  r_prescale, n_prescale;
    logic [15:0] r_period_a, n_period_a;
    logic [17:0] r_period_b, n_period_b;
    logic [3:0]  r_key, n_key;
    logic [7:0]  r_reg24, n_reg24, r_reg25, n_reg25, r_reg26, n_reg26, r_reg27, n_reg27;
    logic [REG_COUNT-1:0] r_reg_vld, n_reg_vld;
    logic        r_rd_vld;

    logic        r_done, n_done;
    logic        r_handled, n_handled;
    logic [7:0]  r_rd, n_rd;
    logic        r_ntf_valid, n_ntf_valid;
    logic [7:0]  r_ntf_reg, n_ntf_reg, r_ntf_data, n_ntf_data;
    logic        r_rst_a, n_rst_a, r_rst_b, n_rst_b;
    logic        r_pend_b, n_pend_b;

    logic [opnbit_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [opnbit_pkg::ACC_W-1:0]     r_acc, n_acc, r_mcand, n_mcand, mul_sum;
    logic [opnbit_pkg::MUL_STEPS-1:0] r_mplier, n_mplier;
    logic [opnbit_pkg::MCAND_W-1:0]   op_n;

    logic              ram_we;
    logic [REG_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;

    opnbit_ram #(
        .WIDTH(8),
        .DEPTH(REG_COUNT)
    ) u_regs (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(REG_AW'(r_sel)),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_state == opnbit_pkg::S_CALC_A) begin
            op_n = opnbit_pkg::MCAND_W'(1024) -
                   opnbit_pkg::MCAND_W'({r_reg24, r_reg25[1:0]});
        end else begin
            op_n = opnbit_pkg::MCAND_W'(9'd256 - {1'b0, r_reg26});
        end
        mul_sum = r_acc + (r_mplier[0] ? r_mcand : '0);
    end

    always_comb begin
        logic       bus_ok;
        logic       do_write;
        logic       calc_a;
        logic       calc_b;
        logic       ovfa;
        logic       ovfb;
        logic [7:0] wr_reg;
        logic [7:0] wr_dat;
        logic [7:0] sel_val;

        n_state     = r_state;
        n_mode      = r_mode;
        n_sel       = r_sel;
        n_latch     = r_latch;
        n_ovf_a     = r_ovf_a;
        n_ovf_b     = r_ovf_b;
        n_run_a     = r_run_a;
        n_run_b     = r_run_b;
        n_arm_a     = r_arm_a;
        n_arm_b     = r_arm_b;
        n_irq       = r_irq;
        n_prescale  = r_prescale;
        n_period_a  = r_period_a;
        n_period_b  = r_period_b;
        n_key       = r_key;
        n_reg24     = r_reg24;
        n_reg25     = r_reg25;
        n_reg26     = r_reg26;
        n_reg27     = r_reg27;
        n_reg_vld   = r_reg_vld;
        n_done      = 1'b0;
        n_handled   = r_handled;
        n_rd        = r_rd;
        n_ntf_valid = r_ntf_valid;
        n_ntf_reg   = r_ntf_reg;
        n_ntf_data  = r_ntf_data;
        n_rst_a     = r_rst_a;
        n_rst_b     = r_rst_b;
        n_pend_b    = r_pend_b;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;

        bus_ok   = r_dev_en && r_new_mach &&
                   (r_req_addr == opnbit_pkg::PORT_CMD || r_req_addr == opnbit_pkg::PORT_DAT);
        do_write = 1'b0;
        calc_a   = 1'b0;
        calc_b   = 1'b0;
        ovfa     = r_ovf_a;
        ovfb     = r_ovf_b;
        wr_reg   = r_sel;
        wr_dat   = (r_req_addr == opnbit_pkg::PORT_CMD) ? r_latch : r_req_wd;
        if (r_sel >= opnbit_pkg::REG_RB_LIMIT) begin
            sel_val = 8'hFF;
        end else begin
            sel_val = r_rd_vld ? ram_rdata : opnbit_pkg::reg_default(r_sel);
        end

        ram_we    = 1'b0;
        ram_waddr = REG_AW'(wr_reg);
        ram_wdata = wr_dat;

        case (r_state)
            opnbit_pkg::S_IDLE: begin
                if (start) begin
                    n_state = opnbit_pkg::S_EXEC;
                end
            end
            opnbit_pkg::S_EXEC: begin
                n_handled   = 1'b0;
                n_rd        = 8'h00;
                n_ntf_valid = 1'b0;
                n_ntf_reg   = 8'h00;
                n_ntf_data  = 8'h00;
                n_rst_a     = 1'b0;
                n_rst_b     = 1'b0;

                if (r_req_op == opnbit_pkg::OP_READ || r_req_op == opnbit_pkg::OP_WRITE) begin
                    if (bus_ok) begin
                        n_handled = 1'b1;
                        if (r_req_op == opnbit_pkg::OP_READ) begin
                            if (r_req_addr == opnbit_pkg::PORT_CMD) begin
                                n_rd = 8'hFF;
                            end else if (r_mode == opnbit_pkg::MODE_STATUS) begin
                                n_rd = {6'd0, r_ovf_b, r_ovf_a};
                            end else if (r_mode == opnbit_pkg::MODE_JOY) begin
                                n_rd = (r_sel == opnbit_pkg::REG_JOY) ? 8'hFF : 8'h00;
                            end else begin
                                n_rd = r_latch;
                            end
                        end else if (r_req_addr == opnbit_pkg::PORT_CMD) begin
                            case (r_req_wd[3:0])
                                opnbit_pkg::CMD_INACTIVE: n_mode = opnbit_pkg::MODE_INACTIVE;
                                opnbit_pkg::CMD_READ: begin
                                    n_mode  = opnbit_pkg::MODE_READ;
                                    n_latch = sel_val;
                                end
                                opnbit_pkg::CMD_WRITE: begin
                                    n_mode   = opnbit_pkg::MODE_WRITE;
                                    do_write = 1'b1;
                                end
                                opnbit_pkg::CMD_ADDRESS: begin
                                    n_mode = opnbit_pkg::MODE_ADDRESS;
                                    n_sel  = r_latch;
                                end
                                opnbit_pkg::CMD_STATUS: n_mode = opnbit_pkg::MODE_STATUS;
                                opnbit_pkg::CMD_JOY:    n_mode = opnbit_pkg::MODE_JOY;
                                default: ;
                            endcase
                        end else begin
                            n_latch = r_req_wd;
                            if (r_mode == opnbit_pkg::MODE_WRITE) begin
                                do_write = 1'b1;
                            end else if (r_mode == opnbit_pkg::MODE_ADDRESS) begin
                                n_sel = r_req_wd;
                            end
                        end
                    end
                end else if (r_dev_en) begin
                    if (r_req_op == opnbit_pkg::OP_TIMER_A) begin
                        if (r_run_a && r_arm_a) begin
                            n_arm_a = 1'b0;
                            n_ovf_a = 1'b1;
                            n_irq   = 1'b1;
                        end
                        n_ntf_valid = 1'b1;
                        n_ntf_reg   = opnbit_pkg::REG_CSM;
                        n_ntf_data  = 8'h00;
                    end else begin
                        if (r_run_b && r_arm_b) begin
                            n_arm_b = 1'b0;
                            n_ovf_b = 1'b1;
                            n_irq   = 1'b1;
                        end
                    end
                end

                if (do_write) begin
                    ram_we                       = 1'b1;
                    n_reg_vld[REG_AW'(wr_reg)]   = 1'b1;
                    if (wr_reg == opnbit_pkg::REG_TMA_HI) n_reg24 = wr_dat;
                    if (wr_reg == opnbit_pkg::REG_TMA_LO) n_reg25 = wr_dat;
                    if (wr_reg == opnbit_pkg::REG_TMB)    n_reg26 = wr_dat;
                    if (wr_reg == opnbit_pkg::REG_TCTL)   n_reg27 = wr_dat;
                    case (wr_reg)
                        opnbit_pkg::REG_TCTL: begin
                            ovfa    = r_ovf_a & ~wr_dat[4];
                            ovfb    = r_ovf_b & ~wr_dat[5];
                            n_ovf_a = ovfa;
                            n_ovf_b = ovfb;
                            if (!ovfa && !ovfb) n_irq = 1'b0;
                            calc_a  = wr_dat[0] && !r_reg27[0];
                            n_run_a = wr_dat[0];
                            n_arm_a = wr_dat[2];
                            calc_b  = wr_dat[1] && !r_reg27[1];
                            n_run_b = wr_dat[1];
                            n_arm_b = wr_dat[3];
                            n_ntf_valid = 1'b1;
                            n_ntf_reg   = opnbit_pkg::REG_TCTL;
                            n_ntf_data  = {wr_dat[7:6], 6'd0};
                        end
                        opnbit_pkg::REG_PSC6: begin
                            if (r_prescale != opnbit_pkg::PSC_3) begin
                                n_prescale = opnbit_pkg::PSC_6;
                                calc_b     = 1'b1;
                            end
                        end
                        opnbit_pkg::REG_PSC3: begin
                            n_prescale = opnbit_pkg::PSC_3;
                            calc_b     = 1'b1;
                        end
                        opnbit_pkg::REG_PSC2: begin
                            n_prescale = opnbit_pkg::PSC_2;
                            calc_b     = 1'b1;
                        end
                        opnbit_pkg::REG_TMA_HI, opnbit_pkg::REG_TMA_LO: calc_a = 1'b1;
                        opnbit_pkg::REG_TMB: calc_b = 1'b1;
                        default: begin
                            if (!((wr_reg >= opnbit_pkg::REG_JOY && wr_reg <= opnbit_pkg::REG_TMB) ||
                                  (wr_reg >= opnbit_pkg::REG_QUIET_LO &&
                                   wr_reg <= opnbit_pkg::REG_PSC2))) begin
                                if (wr_reg == opnbit_pkg::REG_KEY) begin
                                    n_key[wr_dat[1:0]] = |wr_dat[7:4];
                                end
                                n_ntf_valid = 1'b1;
                                n_ntf_reg   = wr_reg;
                                n_ntf_data  = wr_dat;
                            end
                        end
                    endcase
                end

                n_pend_b = calc_b;
                n_cnt    = '0;
                if (calc_a) begin
                    n_state = opnbit_pkg::S_CALC_A;
                end else if (calc_b) begin
                    n_state = opnbit_pkg::S_CALC_B;
                end else begin
                    n_state = opnbit_pkg::S_IDLE;
                    n_done  = 1'b1;
                end
            end
            opnbit_pkg::S_CALC_A, opnbit_pkg::S_CALC_B: begin
                if (r_cnt == '0) begin
                    n_acc    = '0;
                    n_mcand  = opnbit_pkg::ACC_W'(op_n);
                    n_mplier = opnbit_pkg::prescale_mult(r_prescale);
                    n_cnt    = opnbit_pkg::CNT_W'(1);
                end else begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                    n_cnt    = r_cnt + opnbit_pkg::CNT_W'(1);
                    if (r_cnt == opnbit_pkg::CNT_W'(opnbit_pkg::MUL_STEPS)) begin
                        n_cnt = '0;
                        if (r_state == opnbit_pkg::S_CALC_A) begin
                            if (mul_sum[opnbit_pkg::A_SHIFT +: opnbit_pkg::PER_A_W] != r_period_a) begin
                                n_period_a = mul_sum[opnbit_pkg::A_SHIFT +: opnbit_pkg::PER_A_W];
                                n_rst_a    = 1'b1;
                            end
                            if (r_pend_b) begin
                                n_state = opnbit_pkg::S_CALC_B;
                            end else begin
                                n_state = opnbit_pkg::S_IDLE;
                                n_done  = 1'b1;
                            end
                        end else begin
                            if (mul_sum[opnbit_pkg::B_SHIFT +: opnbit_pkg::PER_B_W] != r_period_b) begin
                                n_period_b = mul_sum[opnbit_pkg::B_SHIFT +: opnbit_pkg::PER_B_W];
                                n_rst_b    = 1'b1;
                            end
                            n_state = opnbit_pkg::S_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                end
            end
            default: n_state = opnbit_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= opnbit_pkg::S_IDLE;
            r_mode      <= opnbit_pkg::MODE_INACTIVE;
            r_dev_en    <= 1'b1;
            r_new_mach  <= 1'b1;
            r_sel       <= '0;
            r_latch     <= '0;
            r_ovf_a     <= 1'b0;
            r_ovf_b     <= 1'b0;
            r_run_a     <= 1'b0;
            r_run_b     <= 1'b0;
            r_arm_a     <= 1'b0;
            r_arm_b     <= 1'b0;
            r_irq       <= 1'b0;
            r_prescale  <= opnbit_pkg::PSC_3;
            r_period_a  <= '0;
            r_period_b  <= '0;
            r_key       <= '0;
            r_reg24     <= '0;
            r_reg25     <= '0;
            r_reg26     <= '0;
            r_reg27     <= '0;
            r_reg_vld   <= '0;
            r_done      <= 1'b0;
            r_handled   <= 1'b0;
            r_rd        <= '0;
            r_ntf_valid <= 1'b0;
            r_ntf_reg   <= '0;
            r_ntf_data  <= '0;
            r_rst_a     <= 1'b0;
            r_rst_b     <= 1'b0;
            r_pend_b    <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_sel       <= n_sel;
            r_latch     <= n_latch;
            r_ovf_a     <= n_ovf_a;
            r_ovf_b     <= n_ovf_b;
            r_run_a     <= n_run_a;
            r_run_b     <= n_run_b;
            r_arm_a     <= n_arm_a;
            r_arm_b     <= n_arm_b;
            r_irq       <= n_irq;
            r_prescale  <= n_prescale;
            r_period_a  <= n_period_a;
            r_period_b  <= n_period_b;
            r_key       <= n_key;
            r_reg24     <= n_reg24;
            r_reg25     <= n_reg25;
            r_reg26     <= n_reg26;
            r_reg27     <= n_reg27;
            r_reg_vld   <= n_reg_vld;
            r_done      <= n_done;
            r_handled   <= n_handled;
            r_rd        <= n_rd;
            r_ntf_valid <= n_ntf_valid;
            r_ntf_reg   <= n_ntf_reg;
            r_ntf_data  <= n_ntf_data;
            r_rst_a     <= n_rst_a;
            r_rst_b     <= n_rst_b;
            r_pend_b    <= n_pend_b;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    opnbit_pkg::CFG_DEVICE_ENABLE: r_dev_en   <= i_cfg_data;
                    opnbit_pkg::CFG_NEW_MACHINE:   r_new_mach <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == opnbit_pkg::S_IDLE && start) begin
            r_req_op   <= i_opcode;
            r_req_addr <= i_bus_address;
            r_req_wd   <= i_write_data;
        end
        r_rd_vld <= r_reg_vld[REG_AW'(r_sel)];
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign busy              = (r_state != opnbit_pkg::S_IDLE);
    assign o_done            = r_done;
    assign o_handled         = r_handled;
    assign o_read_data       = r_rd;
    assign o_irq_level       = r_irq;
    assign o_notify_valid    = r_ntf_valid;
    assign o_notify_reg      = r_ntf_reg;
    assign o_notify_data     = r_ntf_data;
    assign o_timer_a_period  = r_period_a;
    assign o_timer_b_period  = r_period_b;
    assign o_timer_a_restart = r_rst_a;
    assign o_timer_b_restart = r_rst_b;
    assign o_key_flags       = r_key;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_irq_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_irq_level |-> (r_ovf_a || r_ovf_b))
        else $error("irq high with no overflow flag");

    a_notify_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_notify_valid) |-> (o_handled || o_notify_reg == opnbit_pkg::REG_CSM))
        else $error("notification without a handled access or timer A event");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_timer_a_period <= 16'd60000) && (o_timer_b_period <= 18'd240000))
        else $error("timer period out of range");

endmodule

@@ tb/opn_bus_interface_timers_test.sv @@
// Self-checking testbench for the sound-chip bus interface and timers: scripted and random traffic.
module opn_bus_interface_timers_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic        handled;
        logic [7:0]  rdata;
        logic        irq;
        logic        nvalid;
        logic [7:0]  nreg;
        logic [7:0]  ndata;
        logic [15:0] per_a;
        logic [17:0] per_b;
        logic        rst_a;
        logic        rst_b;
        logic [3:0]  keys;
    } t_outcome;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wd;
        bit          typed;
        t_outcome    want;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_bus_address = '0;
    logic [7:0]  i_write_data = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        o_done;
    logic        o_handled;
    logic [7:0]  o_read_data;
    logic        o_irq_level;
    logic        o_notify_valid;
    logic [7:0]  o_notify_reg;
    logic [7:0]  o_notify_data;
    logic [15:0] o_timer_a_period;
    logic [17:0] o_timer_b_period;
    logic        o_timer_a_restart;
    logic        o_timer_b_restart;
    logic [3:0]  o_key_flags;

    opn_bus_interface_timers u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_bus_address     (i_bus_address),
        .i_write_data      (i_write_data),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_handled         (o_handled),
        .o_read_data       (o_read_data),
        .o_irq_level       (o_irq_level),
        .o_notify_valid    (o_notify_valid),
        .o_notify_reg      (o_notify_reg),
        .o_notify_data     (o_notify_data),
        .o_timer_a_period  (o_timer_a_period),
        .o_timer_b_period  (o_timer_b_period),
        .o_timer_a_restart (o_timer_a_restart),
        .o_timer_b_restart (o_timer_b_restart),
        .o_key_flags       (o_key_flags)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    logic [7:0]  reg_shadow [256];
    opnbit_pkg::t_port_mode mode_s;
    logic [7:0]  sel_s;
    logic [7:0]  latch_s;
    logic        ovf_a_s;
    logic        ovf_b_s;
    logic        run_a_s;
    logic        run_b_s;
    logic        arm_a_s;
    logic        arm_b_s;
    logic        irq_s;
    logic [2:0]  psc_s;
    logic [15:0] per_a_s;
    logic [17:0] per_b_s;
    logic [3:0]  keys_s;
    logic        enable_s;
    logic        newgen_s;
    logic        ntf_v;
    logic [7:0]  ntf_r;
    logic [7:0]  ntf_d;
    logic        rst_a;
    logic        rst_b;

    t_outcome    awaited_outcomes [$];
    t_script_row script [$];
    bit          steady;
    int          failures = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          settings_seen = 0;
    int          overflows = 0;

    function automatic void reset_shadow();
        logic [7:0] a;
        for (int i = 0; i < 256; i++) begin
            a = 8'(i);
            reg_shadow[i] = 8'h00;
            if (a[1:0] != 2'b11) begin
                case (a[7:4])
                    4'h4:    reg_shadow[i] = 8'h7F;
                    4'h5:    reg_shadow[i] = 8'h1F;
                    4'h8:    reg_shadow[i] = 8'hFF;
                    default: reg_shadow[i] = 8'h00;
                endcase
            end
        end
        reg_shadow[7] = 8'hFF;
        mode_s = opnbit_pkg::MODE_INACTIVE;
        sel_s = '0;
        latch_s = '0;
        {ovf_a_s, ovf_b_s, run_a_s, run_b_s, arm_a_s, arm_b_s, irq_s} = '0;
        psc_s = opnbit_pkg::PSC_3;
        per_a_s = '0;
        per_b_s = '0;
        keys_s = '0;
        enable_s = 1'b1;
        newgen_s = 1'b1;
    endfunction

    function automatic void raise_notify(input logic [7:0] r, input logic [7:0] d);
        ntf_v = 1'b1;
        ntf_r = r;
        ntf_d = d;
    endfunction

    function automatic void refresh_period_a();
        longint cnt;
        longint p;
        cnt = 1024 - longint'({reg_shadow[opnbit_pkg::REG_TMA_HI],
                               reg_shadow[opnbit_pkg::REG_TMA_LO][1:0]});
        p = cnt * longint'(psc_s) * 120000 / 12288;
        if (p[15:0] != per_a_s) begin
            per_a_s = p[15:0];
            rst_a = 1'b1;
        end
    endfunction

    function automatic void refresh_period_b();
        longint cnt;
        longint p;
        cnt = 256 - longint'(reg_shadow[opnbit_pkg::REG_TMB]);
        p = cnt * 192 * longint'(psc_s) * 10000 / 12288;
        if (p[17:0] != per_b_s) begin
            per_b_s = p[17:0];
            rst_b = 1'b1;
        end
    endfunction

    function automatic void store_register(input logic [7:0] r, input logic [7:0] d);
        if (r == opnbit_pkg::REG_TCTL) begin
            if (d[4]) ovf_a_s = 1'b0;
            if (d[5]) ovf_b_s = 1'b0;
            if (!ovf_a_s && !ovf_b_s) irq_s = 1'b0;
            // load a period only on a rising enable bit
            if (d[0]) begin
                if (!reg_shadow[opnbit_pkg::REG_TCTL][0]) refresh_period_a();
                run_a_s = 1'b1;
            end else begin
                run_a_s = 1'b0;
            end
            arm_a_s = d[2];
            if (d[1]) begin
                if (!reg_shadow[opnbit_pkg::REG_TCTL][1]) refresh_period_b();
                run_b_s = 1'b1;
            end else begin
                run_b_s = 1'b0;
            end
            arm_b_s = d[3];
            reg_shadow[r] = d;
            raise_notify(opnbit_pkg::REG_TCTL, d & 8'hC0);
        end else begin
            reg_shadow[r] = d;
            case (r)
                opnbit_pkg::REG_PSC6: if (psc_s != opnbit_pkg::PSC_3) begin
                    psc_s = opnbit_pkg::PSC_6;
                    refresh_period_b();
                end
                opnbit_pkg::REG_PSC3: begin
                    psc_s = opnbit_pkg::PSC_3;
                    refresh_period_b();
                end
                opnbit_pkg::REG_PSC2: begin
                    psc_s = opnbit_pkg::PSC_2;
                    refresh_period_b();
                end
                opnbit_pkg::REG_TMA_HI, opnbit_pkg::REG_TMA_LO: refresh_period_a();
                opnbit_pkg::REG_TMB: refresh_period_b();
                default: begin
                    if (!(r >= opnbit_pkg::REG_JOY && r <= opnbit_pkg::REG_TMB) &&
                        !(r >= opnbit_pkg::REG_QUIET_LO && r <= opnbit_pkg::REG_PSC2)) begin
                        if (r == opnbit_pkg::REG_KEY) keys_s[d[1:0]] = (d >= 8'd16);
                        raise_notify(r, d);
                    end
                end
            endcase
        end
    endfunction

    function automatic t_outcome access_outcome(input logic [1:0] op, input logic [15:0] addr,
                                                input logic [7:0] wd);
        t_outcome o;
        o = '0;
        ntf_v = 1'b0;
        ntf_r = '0;
        ntf_d = '0;
        rst_a = 1'b0;
        rst_b = 1'b0;
        if (op == opnbit_pkg::OP_READ || op == opnbit_pkg::OP_WRITE) begin
            if (enable_s && newgen_s &&
                (addr == opnbit_pkg::PORT_CMD || addr == opnbit_pkg::PORT_DAT)) begin
                o.handled = 1'b1;
                if (op == opnbit_pkg::OP_READ) begin
                    if (addr == opnbit_pkg::PORT_CMD) begin
                        o.rdata = 8'hFF;
                    end else if (mode_s == opnbit_pkg::MODE_STATUS) begin
                        o.rdata = {6'd0, ovf_b_s, ovf_a_s};
                    end else if (mode_s == opnbit_pkg::MODE_JOY) begin
                        o.rdata = (sel_s == opnbit_pkg::REG_JOY) ? 8'hFF : 8'h00;
                    end else begin
                        o.rdata = latch_s;
                    end
                end else if (addr == opnbit_pkg::PORT_CMD) begin
                    case (wd[3:0])
                        opnbit_pkg::CMD_INACTIVE: mode_s = opnbit_pkg::MODE_INACTIVE;
                        opnbit_pkg::CMD_READ: begin
                            mode_s = opnbit_pkg::MODE_READ;
                            latch_s = (sel_s >= opnbit_pkg::REG_RB_LIMIT) ? 8'hFF
                                                                          : reg_shadow[sel_s];
                        end
                        opnbit_pkg::CMD_WRITE: begin
                            mode_s = opnbit_pkg::MODE_WRITE;
                            store_register(sel_s, latch_s);
                        end
                        opnbit_pkg::CMD_ADDRESS: begin
                            mode_s = opnbit_pkg::MODE_ADDRESS;
                            sel_s = latch_s;
                        end
                        opnbit_pkg::CMD_STATUS: mode_s = opnbit_pkg::MODE_STATUS;
                        opnbit_pkg::CMD_JOY: mode_s = opnbit_pkg::MODE_JOY;
                        default: ;
                    endcase
                end else begin
                    latch_s = wd;
                    if (mode_s == opnbit_pkg::MODE_WRITE) store_register(sel_s, latch_s);
                    else if (mode_s == opnbit_pkg::MODE_ADDRESS) sel_s = latch_s;
                end
            end
        end else if (enable_s) begin
            if (op == opnbit_pkg::OP_TIMER_A) begin
                if (run_a_s && arm_a_s) begin
                    arm_a_s = 1'b0;
                    ovf_a_s = 1'b1;
                    irq_s = 1'b1;
                    overflows++;
                end
                raise_notify(opnbit_pkg::REG_CSM, 8'h00);
            end else if (run_b_s && arm_b_s) begin
                arm_b_s = 1'b0;
                ovf_b_s = 1'b1;
                irq_s = 1'b1;
                overflows++;
            end
        end
        o.irq = irq_s;
        o.nvalid = ntf_v;
        o.nreg = ntf_r;
        o.ndata = ntf_d;
        o.per_a = per_a_s;
        o.per_b = per_b_s;
        o.rst_a = rst_a;
        o.rst_b = rst_b;
        o.keys = keys_s;
        return o;
    endfunction

    function automatic t_outcome port_only_outcome(input logic h, input logic [7:0] rd);
        t_outcome o;
        o = '0;
        o.handled = h;
        o.rdata = rd;
        return o;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_register();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return 8'($urandom_range(0, 15));
            2:       return opnbit_pkg::REG_TCTL;
            3:       return opnbit_pkg::REG_KEY;
            4:       return 8'($urandom_range(opnbit_pkg::REG_TMA_HI, opnbit_pkg::REG_TMB));
            5:       return 8'($urandom_range(opnbit_pkg::REG_PSC6, opnbit_pkg::REG_PSC2));
            6:       return 8'($urandom_range(8'h10, 8'h2F));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic issue(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] wd,
                         input bit typed, input t_outcome want);
        int       gap;
        t_outcome got;
        gap = idle_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_bus_address <= addr;
        i_write_data <= wd;
        do @(posedge i_clk); while (busy);
        got = access_outcome(op, addr, wd);
        awaited_outcomes.push_back(typed ? want : got);
        items_sent++;
    endtask

    task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] wd);
        issue(op, addr, wd, 1'b0, '0);
    endtask

    task automatic command(input logic [3:0] code);
        logic [3:0] hi;
        hi = 4'($urandom_range(0, 15));
        send(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {hi, code});
    endtask

    task automatic data_write(input logic [7:0] v);
        send(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, v);
    endtask

    task automatic data_read();
        send(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_sequence();
        int          kind;
        int          n;
        logic [15:0] a;
        steady = ($urandom_range(0, 9) < 2);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            command(opnbit_pkg::CMD_ADDRESS);
            data_write(pick_register());
            command(opnbit_pkg::CMD_WRITE);
            n = $urandom_range(0, 3);
            repeat (n) data_write(8'($urandom_range(0, 255)));
        end else if (kind < 60) begin
            command(opnbit_pkg::CMD_ADDRESS);
            data_write(pick_register());
            command(opnbit_pkg::CMD_READ);
            data_read();
        end else if (kind < 70) begin
            command(opnbit_pkg::CMD_STATUS);
            n = $urandom_range(1, 2);
            repeat (n) data_read();
        end else if (kind < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                send($urandom_range(0, 1) ? opnbit_pkg::OP_TIMER_A : opnbit_pkg::OP_TIMER_B,
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
        end else if (kind < 85) begin
            command(opnbit_pkg::CMD_ADDRESS);
            data_write($urandom_range(0, 1) ? opnbit_pkg::REG_JOY : 8'($urandom_range(0, 255)));
            command(opnbit_pkg::CMD_JOY);
            data_read();
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0:       a = opnbit_pkg::PORT_CMD;
                    1:       a = opnbit_pkg::PORT_DAT;
                    default: a = 16'($urandom_range(0, 65535));
                endcase
                send(2'($urandom_range(0, 3)), a, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic random_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) random_sequence();
    endtask

    task automatic settle();
        start <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic idx, input logic val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == opnbit_pkg::CFG_DEVICE_ENABLE) enable_s = val;
        else newgen_s = val;
    endtask

    task automatic reconfigure(input logic en, input logic gen);
        settle();
        set_config(opnbit_pkg::CFG_DEVICE_ENABLE, en);
        set_config(opnbit_pkg::CFG_NEW_MACHINE, gen);
        settings_seen++;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] wd,
                           input bit typed, input t_outcome want);
        t_script_row row;
        row.op = op;
        row.addr = addr;
        row.wd = wd;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    task automatic build_script();
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_CMD, 8'h00,
                1'b1, port_only_outcome(1'b1, 8'hFF));
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'hFF,
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_READ, 16'h0000, 8'h00, 1'b1, port_only_outcome(1'b0, 8'h00));
        add_row(opnbit_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, port_only_outcome(1'b0, 8'h00));
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, 8'h07,
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_ADDRESS},
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'hF, opnbit_pkg::CMD_READ},
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'h00,
                1'b1, port_only_outcome(1'b1, 8'hFF));
        // unknown command leaves the read mode in place
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, 8'hA5,
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'h00,
                1'b1, port_only_outcome(1'b1, 8'hFF));
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_STATUS},
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'h00,
                1'b1, port_only_outcome(1'b1, 8'h00));
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, opnbit_pkg::REG_JOY, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_ADDRESS},
                1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_JOY},
                1'b0, '0);
        add_row(opnbit_pkg::OP_READ, opnbit_pkg::PORT_DAT, 8'h00, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_ADDRESS},
                1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, opnbit_pkg::REG_TMA_HI, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_WRITE},
                1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, 8'h00, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_ADDRESS},
                1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, opnbit_pkg::REG_TCTL, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_CMD, {4'h0, opnbit_pkg::CMD_WRITE},
                1'b0, '0);
        add_row(opnbit_pkg::OP_TIMER_A, 16'h0000, 8'h00, 1'b0, '0);
        add_row(opnbit_pkg::OP_TIMER_B, 16'hFFFF, 8'hFF, 1'b0, '0);
        add_row(opnbit_pkg::OP_WRITE, opnbit_pkg::PORT_DAT, 8'h3F, 1'b0, '0);
        add_row(opnbit_pkg::OP_TIMER_B, opnbit_pkg::PORT_DAT, 8'h00, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result strobe with no request outstanding");
                failures++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("handled", 18'(want.handled), 18'(o_handled));
                check_field("read_data", 18'(want.rdata), 18'(o_read_data));
                check_field("irq_level", 18'(want.irq), 18'(o_irq_level));
                check_field("notify_valid", 18'(want.nvalid), 18'(o_notify_valid));
                check_field("notify_reg", 18'(want.nreg), 18'(o_notify_reg));
                check_field("notify_data", 18'(want.ndata), 18'(o_notify_data));
                check_field("timer_a_period", 18'(want.per_a), 18'(o_timer_a_period));
                check_field("timer_b_period", want.per_b, o_timer_b_period);
                check_field("timer_a_restart", 18'(want.rst_a), 18'(o_timer_a_restart));
                check_field("timer_b_restart", 18'(want.rst_b), 18'(o_timer_b_restart));
                check_field("key_flags", 18'(want.keys), 18'(o_key_flags));
                results_checked++;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("opn_bus_interface_timers regression: fail");
        $finish;
    end

    initial begin
        reset_shadow();
        steady = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reconfigure(1'b1, 1'b1);
        build_script();
        foreach (script[k]) begin
            issue(script[k].op, script[k].addr, script[k].wd, script[k].typed, script[k].want);
        end
        random_phase(560);
        reconfigure(1'b0, 1'b1);
        random_phase(120);
        reconfigure(1'b1, 1'b0);
        random_phase(120);
        reconfigure(1'b0, 1'b0);
        random_phase(80);
        reconfigure(1'b1, 1'b1);
        random_phase(560);
        settle();
        $display("%0d requests (%0d scripted) over %0d enable settings, %0d results checked",
                 items_sent, script.size(), settings_seen, results_checked);
        $display("timer overflows raised: %0d", overflows);
        if (failures == 0) begin
            $display("opn_bus_interface_timers regression: pass");
        end else begin
            $display("opn_bus_interface_timers regression: fail");
        end
        $finish;
    end

endmodule
